// ===== hw/rtl/color_blob_centroid_tracker_defines.svh =====
// Assertion macros for the color blob centroid tracker.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef COLOR_BLOB_CENTROID_TRACKER_DEFINES_SVH
`define COLOR_BLOB_CENTROID_TRACKER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CBCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CBCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the color blob centroid tracker.
// No dependencies.
package cbct_pkg;

  localparam int CH_W       = 8;
  localparam int THR_W      = 9;
  localparam int LVL_W      = 8;
  localparam int CNT_W      = 23;
  localparam int STRK_LEN_W = 8;
  localparam int FRAME_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [1:0]            COLOR_CHANNEL_RST = 2'd2;
  localparam logic [THR_W-1:0]      REL_THRESHOLD_RST = 9'd128;
  localparam logic [LVL_W-1:0]      MIN_LEVEL_RST     = 8'd200;
  localparam logic [CNT_W-1:0]      MIN_COUNT_RST     = 23'd350;
  localparam logic [STRK_LEN_W-1:0] STREAK_LENGTH_RST = 8'd30;
  localparam logic [FRAME_W-1:0]    FRAME_WIDTH_RST   = 12'd640;
  localparam logic [FRAME_W-1:0]    FRAME_HEIGHT_RST  = 12'd480;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } cbct_chan_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_CHANNEL = 3'd0,
    CFG_REL_THRESHOLD = 3'd1,
    CFG_MIN_LEVEL     = 3'd2,
    CFG_MIN_COUNT     = 3'd3,
    CFG_STREAK_LENGTH = 3'd4,
    CFG_FRAME_WIDTH   = 3'd5,
    CFG_FRAME_HEIGHT  = 3'd6
  } cbct_cfg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cbct_fifo_stat_t;

  typedef struct packed {
    logic min_x;
    logic min_y;
  } cbct_reload_t;

endpackage

// ===== hw/rtl/color_blob_centroid_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the color blob centroid tracker: configuration registers and wiring.
// Depends on cbct_pkg, cbct_front, cbct_fifo and cbct_back.
//
// Pixels stream in with their coordinates; every accepted pixel gives exactly one
// result carrying its color-match flag. Ordinary pixels go through at one per clock
// while neither out_stall nor a frame summary holds the back end, from the front
// register through a two-entry queue into the result register. The pixel marked
// end_of_frame also carries the frame summary (count, centroid, bounding box, blob
// size, target and fire flags); it holds the back end while the bit-per-cycle
// restoring divider forms the centroid, and the queue and front register keep
// taking pixels until they fill. Configuration writes are always ready and take
// effect on the next cycle; write only while no pixel is in flight.
module color_blob_centroid_tracker import cbct_pkg::*; #(
  parameter int COORD_BITS  = 11,
  parameter int STREAK_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       in_chan_zero,
  input  logic [CH_W-1:0]       in_chan_one,
  input  logic [CH_W-1:0]       in_chan_two,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic                  in_end_of_frame,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pixel_match,
  output logic                  out_frame_done,
  output logic [CNT_W-1:0]      out_match_total,
  output logic [COORD_BITS-1:0] out_centre_x,
  output logic [COORD_BITS-1:0] out_centre_y,
  output logic [COORD_BITS:0]   out_box_min_x,
  output logic [COORD_BITS-1:0] out_box_max_x,
  output logic [COORD_BITS:0]   out_box_min_y,
  output logic [COORD_BITS-1:0] out_box_max_y,
  output logic [COORD_BITS-1:0] out_blob_size,
  output logic                  out_target_valid,
  output logic                  out_fire,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ITEM_W = 2 * COORD_BITS + 2;

  logic [1:0]            color_channel_r;
  logic [THR_W-1:0]      rel_threshold_r;
  logic [LVL_W-1:0]      min_level_r;
  logic [CNT_W-1:0]      min_count_r;
  logic [STRK_LEN_W-1:0] streak_length_r;
  logic [FRAME_W-1:0]    frame_width_r;
  logic [FRAME_W-1:0]    frame_height_r;
  cbct_reload_t          reload_r;
  logic                  cfg_wr;

  cbct_fifo_stat_t       fifo_stat;
  logic                  push;
  logic                  pop;
  logic [ITEM_W-1:0]     fr_item;
  logic [ITEM_W-1:0]     rd_item;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_channel_r <= COLOR_CHANNEL_RST;
      rel_threshold_r <= REL_THRESHOLD_RST;
      min_level_r     <= MIN_LEVEL_RST;
      min_count_r     <= MIN_COUNT_RST;
      streak_length_r <= STREAK_LENGTH_RST;
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      reload_r        <= '0;
    end else begin
      reload_r <= '0;
      if (cfg_wr) begin
        unique case (cbct_cfg_idx_t'(cfg_index))
          CFG_COLOR_CHANNEL: color_channel_r <= cfg_data[1:0];
          CFG_REL_THRESHOLD: rel_threshold_r <= cfg_data[THR_W-1:0];
          CFG_MIN_LEVEL:     min_level_r     <= cfg_data[LVL_W-1:0];
          CFG_MIN_COUNT:     min_count_r     <= cfg_data[CNT_W-1:0];
          CFG_STREAK_LENGTH: streak_length_r <= cfg_data[STRK_LEN_W-1:0];
          CFG_FRAME_WIDTH: begin
            frame_width_r  <= cfg_data[FRAME_W-1:0];
            reload_r.min_x <= 1'b1;
          end
          CFG_FRAME_HEIGHT: begin
            frame_height_r <= cfg_data[FRAME_W-1:0];
            reload_r.min_y <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  cbct_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_chan_zero       (in_chan_zero),
    .in_chan_one        (in_chan_one),
    .in_chan_two        (in_chan_two),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .in_end_of_frame    (in_end_of_frame),
    .color_channel      (color_channel_r),
    .relation_threshold (rel_threshold_r),
    .min_level          (min_level_r),
    .fifo_stat          (fifo_stat),
    .push               (push),
    .item               (fr_item)
  );

  cbct_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fr_item),
    .pop     (pop),
    .rd_data (rd_item),
    .stat    (fifo_stat)
  );

  cbct_back #(
    .COORD_BITS  (COORD_BITS),
    .STREAK_BITS (STREAK_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_stat        (fifo_stat),
    .rd_item          (rd_item),
    .pop              (pop),
    .min_count        (min_count_r),
    .streak_length    (streak_length_r),
    .frame_width      (frame_width_r),
    .frame_height     (frame_height_r),
    .reload           (reload_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_match  (out_pixel_match),
    .out_frame_done   (out_frame_done),
    .out_match_total  (out_match_total),
    .out_centre_x     (out_centre_x),
    .out_centre_y     (out_centre_y),
    .out_box_min_x    (out_box_min_x),
    .out_box_max_x    (out_box_max_x),
    .out_box_min_y    (out_box_min_y),
    .out_box_max_y    (out_box_max_y),
    .out_blob_size    (out_blob_size),
    .out_target_valid (out_target_valid),
    .out_fire         (out_fire)
  );

endmodule

// ===== hw/rtl/cbct_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, runs the color test, holds one classified transfer.
// Depends on cbct_pkg.
module cbct_front import cbct_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CH_W-1:0]           in_chan_zero,
  input  logic [CH_W-1:0]           in_chan_one,
  input  logic [CH_W-1:0]           in_chan_two,
  input  logic [COORD_BITS-1:0]     in_pixel_x,
  input  logic [COORD_BITS-1:0]     in_pixel_y,
  input  logic                      in_end_of_frame,
  input  logic [1:0]                color_channel,
  input  logic [THR_W-1:0]          relation_threshold,
  input  logic [LVL_W-1:0]          min_level,
  input  cbct_fifo_stat_t           fifo_stat,
  output logic                      push,
  output logic [2*COORD_BITS+1:0]   item
);

  localparam int SUM_CH_W = CH_W + 2;
  localparam int PROD_W   = THR_W + SUM_CH_W;
  localparam int ITEM_W   = 2 * COORD_BITS + 2;

  logic [CH_W-1:0]     single;
  logic [SUM_CH_W-1:0] ch_sum;
  logic [SUM_CH_W-1:0] div_sum;
  logic [PROD_W-1:0]   rel_lhs;
  logic [PROD_W-1:0]   rel_rhs;
  logic                match;
  logic                accept;
  logic                fr_valid_r;
  logic [ITEM_W-1:0]   fr_item_r;

  always_comb begin
    unique case (color_channel)
      CH_BLUE:  single = in_chan_zero;
      CH_GREEN: single = in_chan_one;
      default:  single = in_chan_two;
    endcase
    ch_sum  = SUM_CH_W'(in_chan_zero) + SUM_CH_W'(in_chan_one) + SUM_CH_W'(in_chan_two);
    div_sum = (ch_sum == '0) ? SUM_CH_W'(1) : ch_sum;
    rel_lhs = PROD_W'({single, 8'b0});
    rel_rhs = PROD_W'(relation_threshold) * PROD_W'(div_sum);
    match   = (rel_lhs >= rel_rhs) && (single >= min_level)
              && (ch_sum >= SUM_CH_W'(min_level));
  end

  assign in_stall = fr_valid_r && fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !fifo_stat.full;
  assign item     = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= {match, in_end_of_frame, in_pixel_x, in_pixel_y};
    end
  end

endmodule

// ===== hw/rtl/cbct_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front and back ends.
// Depends on cbct_pkg and the assertion macro header.
`include "color_blob_centroid_tracker_defines.svh"
module cbct_fifo import cbct_pkg::*; #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output cbct_fifo_stat_t  stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;

  assign stat.full  = (count_r == CNT_W_Q'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `CBCT_ASSERT_NOW(a_push_has_room, push, !stat.full, "transfer into full queue")
  `CBCT_ASSERT_NOW(a_pop_has_data, pop, !stat.empty, "read from empty queue")

endmodule

// ===== hw/rtl/cbct_div.sv =====
`timescale 1ns / 1ps
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on cbct_pkg.
module cbct_div import cbct_pkg::*; #(
  parameter int SUM_W = 34,
  parameter int DIV_W = 23,
  parameter int Q_W   = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend_x,
  input  logic [SUM_W-1:0] dividend_y,
  input  logic [DIV_W-1:0] divisor,
  output logic [Q_W-1:0]   quot_x,
  output logic [Q_W-1:0]   quot_y,
  output logic             done
);

  localparam int STEP_W = $clog2(Q_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  rem_x_r;
  logic [SUM_W-1:0]  rem_y_r;
  logic [SUM_W-1:0]  dsh_r;
  logic [Q_W-1:0]    q_x_r;
  logic [Q_W-1:0]    q_y_r;
  logic              ge_x;
  logic              ge_y;

  assign ge_x   = (rem_x_r >= dsh_r);
  assign ge_y   = (rem_y_r >= dsh_r);
  assign quot_x = q_x_r;
  assign quot_y = q_y_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(Q_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_x_r <= dividend_x;
      rem_y_r <= dividend_y;
      dsh_r   <= SUM_W'(divisor) << (Q_W - 1);
    end else if (busy_r) begin
      if (ge_x) begin
        rem_x_r <= rem_x_r - dsh_r;
      end
      if (ge_y) begin
        rem_y_r <= rem_y_r - dsh_r;
      end
      q_x_r <= {q_x_r[Q_W-2:0], ge_x};
      q_y_r <= {q_y_r[Q_W-2:0], ge_y};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// ===== hw/rtl/cbct_back.sv =====
`timescale 1ns / 1ps
// Back end: frame accumulators, frame-end summary, streak and result register.
// Depends on cbct_pkg, cbct_div and the assertion macro header.
`include "color_blob_centroid_tracker_defines.svh"
module cbct_back import cbct_pkg::*; #(
  parameter int COORD_BITS  = 11,
  parameter int STREAK_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cbct_fifo_stat_t         fifo_stat,
  input  logic [2*COORD_BITS+1:0] rd_item,
  output logic                    pop,
  input  logic [CNT_W-1:0]        min_count,
  input  logic [STRK_LEN_W-1:0]   streak_length,
  input  logic [FRAME_W-1:0]      frame_width,
  input  logic [FRAME_W-1:0]      frame_height,
  input  cbct_reload_t            reload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_pixel_match,
  output logic                    out_frame_done,
  output logic [CNT_W-1:0]        out_match_total,
  output logic [COORD_BITS-1:0]   out_centre_x,
  output logic [COORD_BITS-1:0]   out_centre_y,
  output logic [COORD_BITS:0]     out_box_min_x,
  output logic [COORD_BITS-1:0]   out_box_max_x,
  output logic [COORD_BITS:0]     out_box_min_y,
  output logic [COORD_BITS-1:0]   out_box_max_y,
  output logic [COORD_BITS-1:0]   out_blob_size,
  output logic                    out_target_valid,
  output logic                    out_fire
);

  localparam int CB     = COORD_BITS;
  localparam int BOX_W  = CB + 1;
  localparam int SUM_W  = CNT_W + CB;
  localparam int ITEM_W = 2 * CB + 2;
  localparam int S_W    = CB + 3;
  localparam int CMP_W  = (STREAK_BITS > STRK_LEN_W) ? STREAK_BITS : STRK_LEN_W;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;

  logic          it_match;
  logic          it_eof;
  logic [CB-1:0] it_x;
  logic [CB-1:0] it_y;
  logic          out_free;
  logic          fin_go;
  logic          div_start;
  logic          div_done;
  logic [CB-1:0] quot_x;
  logic [CB-1:0] quot_y;
  logic [CNT_W-1:0] div_dvs;

  logic [CNT_W-1:0] count_r, count_upd, count_nxt;
  logic [SUM_W-1:0] sumx_r, sumx_upd, sumx_nxt;
  logic [SUM_W-1:0] sumy_r, sumy_upd, sumy_nxt;
  logic [BOX_W-1:0] minx_r, minx_upd, minx_nxt;
  logic [CB-1:0]    maxx_r, maxx_upd, maxx_nxt;
  logic [BOX_W-1:0] miny_r, miny_upd, miny_nxt;
  logic [CB-1:0]    maxy_r, maxy_upd, maxy_nxt;

  logic [CNT_W-1:0] sn_count_r;
  logic [BOX_W-1:0] sn_minx_r;
  logic [CB-1:0]    sn_maxx_r;
  logic [BOX_W-1:0] sn_miny_r;
  logic [CB-1:0]    sn_maxy_r;
  logic             sn_match_r;

  logic [STREAK_BITS-1:0] streak_cnt_r, streak_cnt_nxt, streak_inc;
  logic [CB-1:0]          streak_min_r, streak_min_nxt;

  logic signed [S_W-1:0] s_sum;
  logic signed [S_W-1:0] s_rnd;
  logic [S_W-1:0]        half_u;
  logic [CB-1:0]         local_sz;
  logic [CB-1:0]         size_out;
  logic                  tgt;
  logic                  fire;

  logic             out_valid_r;
  logic             out_match_r;
  logic             out_done_r;
  logic [CNT_W-1:0] out_total_r;
  logic [CB-1:0]    out_cx_r;
  logic [CB-1:0]    out_cy_r;
  logic [BOX_W-1:0] out_minx_r;
  logic [CB-1:0]    out_maxx_r;
  logic [BOX_W-1:0] out_miny_r;
  logic [CB-1:0]    out_maxy_r;
  logic [CB-1:0]    out_size_r;
  logic             out_tgt_r;
  logic             out_fire_r;

  assign it_match = rd_item[ITEM_W-1];
  assign it_eof   = rd_item[ITEM_W-2];
  assign it_x     = rd_item[2*CB-1:CB];
  assign it_y     = rd_item[CB-1:0];

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_RUN) && !fifo_stat.empty && out_free;
  assign fin_go    = (state_r == ST_FIN) && out_free;
  assign div_start = pop && it_eof;
  assign div_dvs   = (count_upd == '0) ? CNT_W'(1) : count_upd;

  always_comb begin
    count_upd = count_r;
    sumx_upd  = sumx_r;
    sumy_upd  = sumy_r;
    minx_upd  = minx_r;
    maxx_upd  = maxx_r;
    miny_upd  = miny_r;
    maxy_upd  = maxy_r;
    if (it_match) begin
      if (count_r != '1) begin
        count_upd = count_r + CNT_W'(1);
        sumx_upd  = sumx_r + SUM_W'(it_x);
        sumy_upd  = sumy_r + SUM_W'(it_y);
      end
      if (BOX_W'(it_x) < minx_r) begin
        minx_upd = BOX_W'(it_x);
      end
      if (it_x > maxx_r) begin
        maxx_upd = it_x;
      end
      if (BOX_W'(it_y) < miny_r) begin
        miny_upd = BOX_W'(it_y);
      end
      if (it_y > maxy_r) begin
        maxy_upd = it_y;
      end
    end

    count_nxt = count_r;
    sumx_nxt  = sumx_r;
    sumy_nxt  = sumy_r;
    minx_nxt  = minx_r;
    maxx_nxt  = maxx_r;
    miny_nxt  = miny_r;
    maxy_nxt  = maxy_r;
    if (reload.min_x && (count_r == '0)) begin
      minx_nxt = BOX_W'(frame_width);
    end
    if (reload.min_y && (count_r == '0)) begin
      miny_nxt = BOX_W'(frame_height);
    end
    if (pop) begin
      if (it_eof) begin
        count_nxt = '0;
        sumx_nxt  = '0;
        sumy_nxt  = '0;
        minx_nxt  = BOX_W'(frame_width);
        maxx_nxt  = '0;
        miny_nxt  = BOX_W'(frame_height);
        maxy_nxt  = '0;
      end else begin
        count_nxt = count_upd;
        sumx_nxt  = sumx_upd;
        sumy_nxt  = sumy_upd;
        minx_nxt  = minx_upd;
        maxx_nxt  = maxx_upd;
        miny_nxt  = miny_upd;
        maxy_nxt  = maxy_upd;
      end
    end
  end

  always_comb begin
    s_sum = $signed(S_W'(sn_maxx_r)) - $signed(S_W'(sn_minx_r))
            + $signed(S_W'(sn_maxy_r)) - $signed(S_W'(sn_miny_r));
    s_rnd  = s_sum + $signed(S_W'(1));
    half_u = $unsigned(s_rnd) >> 1;
    if (s_sum[S_W-1]) begin
      local_sz = '0;
    end else if (half_u > S_W'({CB{1'b1}})) begin
      local_sz = '1;
    end else begin
      local_sz = half_u[CB-1:0];
    end
    size_out   = (local_sz < streak_min_r) ? local_sz : streak_min_r;
    streak_inc = (streak_cnt_r == '1) ? streak_cnt_r : streak_cnt_r + STREAK_BITS'(1);

    streak_cnt_nxt = streak_cnt_r;
    streak_min_nxt = streak_min_r;
    tgt  = 1'b0;
    fire = 1'b0;
    if ((quot_x != '0) && (quot_y != '0)) begin
      if (sn_count_r > min_count) begin
        tgt = 1'b1;
        if (CMP_W'(streak_inc) >= CMP_W'(streak_length)) begin
          fire           = 1'b1;
          streak_cnt_nxt = '0;
          streak_min_nxt = '1;
        end else begin
          streak_cnt_nxt = streak_inc;
          streak_min_nxt = size_out;
        end
      end else begin
        streak_cnt_nxt = '0;
        streak_min_nxt = '1;
      end
    end
  end

  cbct_div #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W),
    .Q_W   (CB)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_x (sumx_upd),
    .dividend_y (sumy_upd),
    .divisor    (div_dvs),
    .quot_x     (quot_x),
    .quot_y     (quot_y),
    .done       (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      sumx_r       <= '0;
      sumy_r       <= '0;
      minx_r       <= BOX_W'(FRAME_WIDTH_RST);
      maxx_r       <= '0;
      miny_r       <= BOX_W'(FRAME_HEIGHT_RST);
      maxy_r       <= '0;
      streak_cnt_r <= '0;
      streak_min_r <= '1;
    end else begin
      count_r <= count_nxt;
      sumx_r  <= sumx_nxt;
      sumy_r  <= sumy_nxt;
      minx_r  <= minx_nxt;
      maxx_r  <= maxx_nxt;
      miny_r  <= miny_nxt;
      maxy_r  <= maxy_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_RUN: begin
          if (pop) begin
            if (it_eof) begin
              sn_count_r <= count_upd;
              sn_minx_r  <= minx_upd;
              sn_maxx_r  <= maxx_upd;
              sn_miny_r  <= miny_upd;
              sn_maxy_r  <= maxy_upd;
              sn_match_r <= it_match;
              state_r    <= ST_DIV;
            end else begin
              out_valid_r <= 1'b1;
              out_match_r <= it_match;
              out_done_r  <= 1'b0;
              out_total_r <= '0;
              out_cx_r    <= '0;
              out_cy_r    <= '0;
              out_minx_r  <= '0;
              out_maxx_r  <= '0;
              out_miny_r  <= '0;
              out_maxy_r  <= '0;
              out_size_r  <= '0;
              out_tgt_r   <= 1'b0;
              out_fire_r  <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_r  <= 1'b1;
            out_match_r  <= sn_match_r;
            out_done_r   <= 1'b1;
            out_total_r  <= sn_count_r;
            out_cx_r     <= quot_x;
            out_cy_r     <= quot_y;
            out_minx_r   <= sn_minx_r;
            out_maxx_r   <= sn_maxx_r;
            out_miny_r   <= sn_miny_r;
            out_maxy_r   <= sn_maxy_r;
            out_size_r   <= size_out;
            out_tgt_r    <= tgt;
            out_fire_r   <= fire;
            streak_cnt_r <= streak_cnt_nxt;
            streak_min_r <= streak_min_nxt;
            state_r      <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_match  = out_match_r;
  assign out_frame_done   = out_done_r;
  assign out_match_total  = out_total_r;
  assign out_centre_x     = out_cx_r;
  assign out_centre_y     = out_cy_r;
  assign out_box_min_x    = out_minx_r;
  assign out_box_max_x    = out_maxx_r;
  assign out_box_min_y    = out_miny_r;
  assign out_box_max_y    = out_maxy_r;
  assign out_blob_size    = out_size_r;
  assign out_target_valid = out_tgt_r;
  assign out_fire         = out_fire_r;

  `CBCT_ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV, "divider done outside wait")
  `CBCT_ASSERT_NOW(a_box_x_order, count_r != '0, BOX_W'(maxx_r) >= minx_r, "x box inverted")
  `CBCT_ASSERT_NOW(a_box_y_order, count_r != '0, BOX_W'(maxy_r) >= miny_r, "y box inverted")
  `CBCT_ASSERT_NEXT(a_fin_shows_summary, fin_go, out_valid_r && out_done_r, "summary not shown")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for color_blob_centroid_tracker: directed and random pixel frames against an
// in-bench model of the match test, frame accumulators and streak logic.
// Depends on cbct_pkg and the tracker RTL.
module tb;
  import cbct_pkg::*;

  localparam int CB          = 11;
  localparam int SB          = 8;
  localparam int SIZE_MAX    = (1 << CB) - 1;
  localparam int SETTLE      = CB + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_GOAL   = 1700;

  typedef struct packed {
    logic [2:0][CH_W-1:0] chan;
    logic [CB-1:0]        x;
    logic [CB-1:0]        y;
    logic                 eof;
  } pixel_t;

  typedef struct {
    logic            pixel_match;
    logic            frame_done;
    logic [CNT_W-1:0] match_total;
    logic [CB-1:0]   centre_x;
    logic [CB-1:0]   centre_y;
    logic [CB:0]     box_min_x;
    logic [CB-1:0]   box_max_x;
    logic [CB:0]     box_min_y;
    logic [CB-1:0]   box_max_y;
    logic [CB-1:0]   blob_size;
    logic            target_valid;
    logic            fire;
  } frame_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       in_chan_zero = '0;
  logic [CH_W-1:0]       in_chan_one = '0;
  logic [CH_W-1:0]       in_chan_two = '0;
  logic [CB-1:0]         in_pixel_x = '0;
  logic [CB-1:0]         in_pixel_y = '0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_pixel_match;
  logic                  out_frame_done;
  logic [CNT_W-1:0]      out_match_total;
  logic [CB-1:0]         out_centre_x;
  logic [CB-1:0]         out_centre_y;
  logic [CB:0]           out_box_min_x;
  logic [CB-1:0]         out_box_max_x;
  logic [CB:0]           out_box_min_y;
  logic [CB-1:0]         out_box_max_y;
  logic [CB-1:0]         out_blob_size;
  logic                  out_target_valid;
  logic                  out_fire;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_COLOR_CHANNEL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  color_blob_centroid_tracker #(
    .COORD_BITS (CB),
    .STREAK_BITS(SB)
  ) dut (.*);

  // model configuration
  logic [1:0]            sel_cfg;
  logic [THR_W-1:0]      thr_cfg;
  logic [LVL_W-1:0]      lvl_cfg;
  logic [CNT_W-1:0]      min_count_cfg;
  logic [STRK_LEN_W-1:0] streak_len_cfg;
  logic [FRAME_W-1:0]    width_cfg;
  logic [FRAME_W-1:0]    height_cfg;

  // model state
  logic [CNT_W-1:0]      hit_count;
  longint unsigned       sum_x;
  longint unsigned       sum_y;
  logic [CB:0]           box_min_x;
  logic [CB-1:0]         box_max_x;
  logic [CB:0]           box_min_y;
  logic [CB-1:0]         box_max_y;
  logic [SB-1:0]         streak_count;
  logic [CB-1:0]         streak_min;

  pixel_t        pixel_q[$];
  frame_result_t expected_q[$];
  pixel_t        cur_pixel;
  frame_result_t wanted;
  int            pixels_queued = 0;
  int            mismatches = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;
  bit            calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, seen, want));
  endtask

  task automatic clear_frame();
    hit_count = '0;
    sum_x     = 0;
    sum_y     = 0;
    box_min_x = width_cfg;
    box_max_x = '0;
    box_min_y = height_cfg;
    box_max_y = '0;
  endtask

  task automatic clear_streak();
    streak_count = '0;
    streak_min   = '1;
  endtask

  task automatic reset_tracker();
    sel_cfg        = COLOR_CHANNEL_RST;
    thr_cfg        = REL_THRESHOLD_RST;
    lvl_cfg        = MIN_LEVEL_RST;
    min_count_cfg  = MIN_COUNT_RST;
    streak_len_cfg = STREAK_LENGTH_RST;
    width_cfg      = FRAME_WIDTH_RST;
    height_cfg     = FRAME_HEIGHT_RST;
    clear_frame();
    clear_streak();
  endtask

  // Advance the model by one pixel and queue the result it should produce.
  task automatic track_pixel(input pixel_t p);
    logic [1:0]      sel;
    int              single;
    int              total;
    int              divisor;
    int              spread;
    int              local_size;
    logic            hit;
    longint unsigned div;
    longint unsigned mean_x;
    longint unsigned mean_y;
    frame_result_t   r;
    sel     = (sel_cfg > CH_RED) ? 2'(CH_RED) : sel_cfg;
    single  = p.chan[sel];
    total   = int'(p.chan[0]) + int'(p.chan[1]) + int'(p.chan[2]);
    divisor = (total == 0) ? 1 : total;
    hit     = (single * 256 >= int'(thr_cfg) * divisor) && single >= int'(lvl_cfg)
              && total >= int'(lvl_cfg);
    if (hit) begin
      if (hit_count != '1) begin
        hit_count++;
        sum_x += p.x;
        sum_y += p.y;
      end
      if (p.x < box_min_x) box_min_x = p.x;
      if (p.x > box_max_x) box_max_x = p.x;
      if (p.y < box_min_y) box_min_y = p.y;
      if (p.y > box_max_y) box_max_y = p.y;
    end
    r = '{default: '0};
    r.pixel_match = hit;
    if (p.eof) begin
      div        = (hit_count == 0) ? 1 : hit_count;
      mean_x     = sum_x / div;
      mean_y     = sum_y / div;
      r.centre_x = mean_x[CB-1:0];
      r.centre_y = mean_y[CB-1:0];
      spread     = (int'(box_max_x) - int'(box_min_x)) + (int'(box_max_y) - int'(box_min_y));
      local_size = (spread < 0) ? 0 : (spread + 1) / 2;
      if (local_size > SIZE_MAX) local_size = SIZE_MAX;
      r.blob_size = (local_size < int'(streak_min)) ? local_size : streak_min;
      if (r.centre_x != 0 && r.centre_y != 0) begin
        if (hit_count > min_count_cfg) begin
          r.target_valid = 1'b1;
          if (streak_count != '1) streak_count++;
          if (local_size < int'(streak_min)) streak_min = local_size;
          if (streak_count >= streak_len_cfg) begin
            r.fire = 1'b1;
            clear_streak();
          end
        end else begin
          clear_streak();
        end
      end
      r.frame_done  = 1'b1;
      r.match_total = hit_count;
      r.box_min_x   = box_min_x;
      r.box_max_x   = box_max_x;
      r.box_min_y   = box_min_y;
      r.box_max_y   = box_max_y;
      clear_frame();
    end
    expected_q.push_back(r);
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) track_pixel(cur_pixel);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 9);
        end else if (pixel_q.size() != 0) begin
          cur_pixel = pixel_q.pop_front();
          in_chan_zero    <= cur_pixel.chan[0];
          in_chan_one     <= cur_pixel.chan[1];
          in_chan_two     <= cur_pixel.chan[2];
          in_pixel_x      <= cur_pixel.x;
          in_pixel_y      <= cur_pixel.y;
          in_end_of_frame <= cur_pixel.eof;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no pixel pending");
      end else begin
        wanted = expected_q.pop_front();
        check_field("pixel_match", out_pixel_match, wanted.pixel_match);
        check_field("frame_done", out_frame_done, wanted.frame_done);
        check_field("match_total", out_match_total, wanted.match_total);
        check_field("centre_x", out_centre_x, wanted.centre_x);
        check_field("centre_y", out_centre_y, wanted.centre_y);
        check_field("box_min_x", out_box_min_x, wanted.box_min_x);
        check_field("box_max_x", out_box_max_x, wanted.box_max_x);
        check_field("box_min_y", out_box_min_y, wanted.box_min_y);
        check_field("box_max_y", out_box_max_y, wanted.box_max_y);
        check_field("blob_size", out_blob_size, wanted.blob_size);
        check_field("target_valid", out_target_valid, wanted.target_valid);
        check_field("fire", out_fire, wanted.fire);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("color_blob_centroid_tracker verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cbct_cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLOR_CHANNEL: sel_cfg = value;
      CFG_REL_THRESHOLD: thr_cfg = value;
      CFG_MIN_LEVEL:     lvl_cfg = value;
      CFG_MIN_COUNT:     min_count_cfg = value;
      CFG_STREAK_LENGTH: streak_len_cfg = value;
      CFG_FRAME_WIDTH: begin
        width_cfg = value;
        if (hit_count == 0) box_min_x = width_cfg;
      end
      CFG_FRAME_HEIGHT: begin
        height_cfg = value;
        if (hit_count == 0) box_min_y = height_cfg;
      end
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int ch, input int thr, input int lvl, input int mc,
                               input int sl, input int fw, input int fh);
    wait_idle();
    write_reg(CFG_COLOR_CHANNEL, ch);
    write_reg(CFG_REL_THRESHOLD, thr);
    write_reg(CFG_MIN_LEVEL, lvl);
    write_reg(CFG_MIN_COUNT, mc);
    write_reg(CFG_STREAK_LENGTH, sl);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
  endtask

  task automatic random_setting();
    apply_setting($urandom_range(0, 3),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 120),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, 10),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                  ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4095),
                  ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 4095));
  endtask

  task automatic queue_pixel(input pixel_t p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  function automatic pixel_t make_pixel(input int b, input int g, input int r,
                                        input int x, input int y, input bit eof);
    pixel_t p;
    p.chan = {8'(r), 8'(g), 8'(b)};
    p.x    = x;
    p.y    = y;
    p.eof  = eof;
    return p;
  endfunction

  function automatic int coord_near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, 2 * spread) - spread;
    return (v < 0) ? 0 : (v > SIZE_MAX) ? SIZE_MAX : v;
  endfunction

  // One frame around a random blob; part of the pixels carry the wanted color.
  task automatic queue_frame(input int len);
    int     cx;
    int     cy;
    int     spread;
    int     hit_pct;
    int     hi;
    int     sel;
    pixel_t p;
    cx      = $urandom_range(0, SIZE_MAX);
    cy      = $urandom_range(0, SIZE_MAX);
    spread  = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(1, 64);
    hit_pct = $urandom_range(0, 100);
    sel     = (sel_cfg > CH_RED) ? CH_RED : sel_cfg;
    for (int k = 0; k < len; k++) begin
      p.x = coord_near(cx, spread);
      p.y = coord_near(cy, spread);
      if ($urandom_range(1, 100) <= hit_pct) begin
        hi = $urandom_range(lvl_cfg, 255);
        for (int j = 0; j < 3; j++)
          p.chan[j] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, hi / 3);
        p.chan[sel] = hi;
      end else begin
        p.chan = $urandom;
      end
      p.eof = (k == len - 1);
      queue_pixel(p);
    end
  endtask

  task automatic queue_random_phase(input int n);
    int     start;
    pixel_t p;
    start = pixels_queued;
    while (pixels_queued - start < n) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          p.chan = $urandom;
          p.x    = $urandom;
          p.y    = $urandom;
          p.eof  = ($urandom_range(0, 15) == 0);
          queue_pixel(p);
        end
      end else begin
        queue_frame(($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    reset_tracker();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(CH_RED, 128, 200, 2, 1, 640, 480);
    queue_pixel(make_pixel(0, 0, 0, 0, 0, 0));
    queue_pixel(make_pixel(255, 255, 255, 2047, 2047, 0));
    queue_pixel(make_pixel(0, 0, 255, 2047, 0, 0));
    queue_pixel(make_pixel(0, 0, 200, 0, 2047, 0));
    queue_pixel(make_pixel(0, 0, 199, 5, 5, 0));
    queue_pixel(make_pixel(55, 0, 200, 1, 1, 0));
    queue_pixel(make_pixel(200, 200, 200, 9, 9, 0));
    queue_pixel(make_pixel(0, 128, 255, 700, 300, 1));
    // empty frame
    queue_pixel(make_pixel(10, 20, 30, 3, 3, 1));
    // zero centre leaves the streak alone
    queue_pixel(make_pixel(0, 0, 255, 0, 10, 0));
    queue_pixel(make_pixel(0, 0, 255, 0, 11, 0));
    queue_pixel(make_pixel(0, 0, 255, 0, 12, 1));
    // too few matches
    queue_pixel(make_pixel(0, 0, 255, 50, 50, 1));
    // target frame that fires
    queue_pixel(make_pixel(0, 0, 230, 100, 100, 0));
    queue_pixel(make_pixel(0, 0, 230, 101, 101, 0));
    queue_pixel(make_pixel(0, 0, 240, 102, 102, 1));
    // frame size written mid-frame, with and without matches so far
    queue_pixel(make_pixel(0, 0, 255, 1000, 1000, 0));
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 100);
    write_reg(CFG_FRAME_HEIGHT, 90);
    queue_pixel(make_pixel(1, 1, 1, 3, 3, 1));
    queue_pixel(make_pixel(1, 1, 1, 4, 4, 0));
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 300);
    write_reg(CFG_FRAME_HEIGHT, 2048);
    queue_pixel(make_pixel(1, 1, 1, 5, 5, 1));

    apply_setting(CH_BLUE, 0, 0, 0, 0, 1, 1);
    queue_random_phase(150);
    apply_setting(CH_GREEN, 256, 255, 8388607, 255, 4095, 4095);
    queue_random_phase(120);
    apply_setting(3, 511, 128, 4194304, 255, 0, 0);
    queue_random_phase(100);
    apply_setting(3, 100, 60, 3, 3, 2048, 2048);
    queue_random_phase(150);

    while (pixels_queued < ITEM_GOAL) begin
      calm = ($urandom_range(0, 4) == 0);
      random_setting();
      queue_random_phase($urandom_range(100, 200));
    end

    wait_idle();
    calm = 1'b1;
    random_setting();
    queue_random_phase(120);
    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("color_blob_centroid_tracker verification clean");
    end else begin
      $display("color_blob_centroid_tracker verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cbct_pkg.sv
hw/rtl/cbct_front.sv
hw/rtl/cbct_fifo.sv
hw/rtl/cbct_div.sv
hw/rtl/cbct_back.sv
hw/rtl/color_blob_centroid_tracker.sv
tb/sv/tb.sv
